### rtl/cba_pkg.sv
`default_nettype none

package cba_pkg;

	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned REQ_W      = 13;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned OFF_W      = 12;
	localparam int unsigned CFG_W      = 5;
	localparam int unsigned CFG_RESET  = 16;
	localparam int unsigned ALIGN_UNIT = 16;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC   = 2'd0,
		FUNC_CREATE  = 2'd1,
		FUNC_RELEASE = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_INVALID = 2'd1,
		STAT_NO_ROOM = 2'd2,
		STAT_NOP     = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              busy;
		logic              found;
		logic [REQ_W-1:0]  size;
		logic [IDX_W-1:0]  idx;
		logic [OFF_W-1:0]  off;
	} token_t;

endpackage

`default_nettype wire

### rtl/cba_req_if.sv
`default_nettype none

interface cba_req_if;
	import cba_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [REQ_W-1:0]  req_bytes;

	modport source(output valid, func, req_bytes, input ready);
	modport sink(input valid, func, req_bytes, output ready);
endinterface

`default_nettype wire

### rtl/cba_rsp_if.sv
`default_nettype none

interface cba_rsp_if;
	import cba_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    chunk_index;
	logic [OFF_W-1:0]    byte_offset;

	modport source(output valid, status, chunk_index, byte_offset, input ready);
	modport sink(input valid, status, chunk_index, byte_offset, output ready);
endinterface

`default_nettype wire

### rtl/cba_cell.sv
`default_nettype none

module cba_cell #(
	parameter int unsigned CELL_IDX    = 0,
	parameter int unsigned NUM_CHUNKS  = 16,
	parameter int unsigned CHUNK_BYTES = 4096
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              clr,
	input  wire logic [$clog2(NUM_CHUNKS+1)-1:0]   count,
	input  wire cba_pkg::token_t                   tok_in,
	output cba_pkg::token_t                        tok_out
);
	import cba_pkg::*;

	localparam int unsigned FILL_W = $clog2(CHUNK_BYTES + ALIGN_UNIT);
	localparam int unsigned SUM_W  = ((FILL_W > REQ_W) ? FILL_W : REQ_W) + 1;

	logic [FILL_W-1:0] fill_q;
	token_t            tok_q;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  rounded;
	logic              active;
	logic              claim;
	token_t            tok_d;

	always_comb begin
		sum     = SUM_W'(fill_q) + SUM_W'(tok_in.size);
		rounded = (sum + SUM_W'(ALIGN_UNIT - 1)) & ~SUM_W'(ALIGN_UNIT - 1);
		active  = 32'(count) > CELL_IDX;
		claim   = tok_in.busy && !tok_in.found && active && (sum <= SUM_W'(CHUNK_BYTES));
		tok_d   = tok_in;
		if (claim) begin
			tok_d.found = 1'b1;
			tok_d.idx   = IDX_W'(CELL_IDX);
			tok_d.off   = OFF_W'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clr) begin
			fill_q <= '0;
		end else if (claim) begin
			fill_q <= FILL_W'(rounded);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

### rtl/chunked_bump_allocator.sv
`default_nettype none

// Bump allocator over NUM_CHUNKS chunks of CHUNK_BYTES bytes. Each chunk's fill
// offset lives in its own cell; an allocate sends a search token down the row of
// cells, one cell per cycle, and the first active chunk with room claims it and
// advances its fill by the size rounded up to 16 bytes. An allocate that starts
// a search returns its result once the token has walked through the whole
// cell row; create, release and rejected requests return in the next cycle.
// One request is worked on at a time, but a new one is taken while the
// previous result is being handed off. chunk_count (written on cfg_we)
// selects how many chunks take part and saturates at NUM_CHUNKS.
module chunked_bump_allocator #(
	parameter int unsigned NUM_CHUNKS  = 16,
	parameter int unsigned CHUNK_BYTES = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	cba_req_if.sink                           req,
	cba_rsp_if.source                         rsp,
	input  wire logic                         cfg_we,
	input  wire logic [cba_pkg::CFG_W-1:0]    cfg_wdata
);
	import cba_pkg::*;

	localparam int unsigned CNT_W = $clog2(NUM_CHUNKS + 1);

	logic [CFG_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    count_sat;
	logic                pool_q;
	state_t              state_q;
	state_t              state_d;
	logic                in_ready;
	logic                accept;
	logic                size_ok;
	logic                scan_start;
	logic                clr;
	status_t             imm_status;
	logic                pool_d;

	logic                res_valid_q;
	status_t             res_status_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [OFF_W-1:0]    res_off_q;

	token_t              tok [NUM_CHUNKS+1];
	logic [NUM_CHUNKS-1:0] busy_vec;
	logic                scan_done;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CFG_W'(CFG_RESET);
		end else if (cfg_we) begin
			cnt_q <= cfg_wdata;
		end
	end

	assign count_sat = (32'(cnt_q) > NUM_CHUNKS) ? CNT_W'(NUM_CHUNKS) : CNT_W'(cnt_q);

	// request decode
	assign accept  = req.valid && in_ready;
	assign size_ok = (req.req_bytes != '0) && (32'(req.req_bytes) <= CHUNK_BYTES);

	always_comb begin
		scan_start = 1'b0;
		clr        = 1'b0;
		pool_d     = pool_q;
		imm_status = STAT_INVALID;
		unique case (req.func)
			FUNC_ALLOC: begin
				scan_start = accept && pool_q && size_ok;
			end
			FUNC_CREATE: begin
				imm_status = pool_q ? STAT_NOP : STAT_DONE;
				clr        = accept && !pool_q;
				pool_d     = 1'b1;
			end
			FUNC_RELEASE: begin
				imm_status = pool_q ? STAT_DONE : STAT_NOP;
				clr        = accept && pool_q;
				pool_d     = 1'b0;
			end
			default: begin
				imm_status = STAT_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= 1'b0;
		end else if (accept) begin
			pool_q <= pool_d;
		end
	end

	// state machine
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (scan_start) state_d = ST_SCAN;
			ST_SCAN: if (scan_done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: in_ready = !res_valid_q || rsp.ready;
			ST_SCAN: in_ready = 1'b0;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req.ready = in_ready;

	// cell row
	always_comb begin
		tok[0].busy  = scan_start;
		tok[0].found = 1'b0;
		tok[0].size  = req.req_bytes;
		tok[0].idx   = '0;
		tok[0].off   = '0;
	end

	for (genvar i = 0; i < NUM_CHUNKS; i++) begin : g_cell
		cba_cell #(
			.CELL_IDX    (i),
			.NUM_CHUNKS  (NUM_CHUNKS),
			.CHUNK_BYTES (CHUNK_BYTES)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (clr),
			.count   (count_sat),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
		assign busy_vec[i] = tok[i+1].busy;
	end

	assign scan_done = tok[NUM_CHUNKS].busy;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (scan_done || (accept && !scan_start)) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_done) begin
			res_status_q <= tok[NUM_CHUNKS].found ? STAT_DONE : STAT_NO_ROOM;
			res_idx_q    <= tok[NUM_CHUNKS].idx;
			res_off_q    <= tok[NUM_CHUNKS].off;
		end else if (accept && !scan_start) begin
			res_status_q <= imm_status;
			res_idx_q    <= '0;
			res_off_q    <= '0;
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.status      = res_status_q;
	assign rsp.chunk_index = res_idx_q;
	assign rsp.byte_offset = res_off_q;

`ifndef SYNTH
	// at most one search token in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(busy_vec))
		else $error("more than one search token in flight");

	// no token in the row while idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (busy_vec == '0))
		else $error("search token present while idle");

	// a finished search never finds the result register occupied
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> !res_valid_q)
		else $error("search result would overwrite pending result");

	// returned offsets are 16 byte aligned
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_off_q[3:0] == 4'd0))
		else $error("unaligned byte offset");
`endif

endmodule

`default_nettype wire

### tb/chunked_bump_allocator_test.sv
`default_nettype none

module chunked_bump_allocator_test;
	import cba_pkg::*;

	localparam int unsigned NUM_CHUNKS      = 16;
	localparam int unsigned CHUNK_BYTES     = 4096;
	localparam int unsigned DRAIN_CYCLES    = NUM_CHUNKS + 6;
	localparam int unsigned RSP_HOLD_CYCLES = 300;
	localparam int unsigned STALL_LIMIT     = 2000;
	localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] chunk_index;
		logic [OFF_W-1:0] byte_offset;
	} alloc_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	cba_req_if req_ch();
	cba_rsp_if rsp_ch();

	chunked_bump_allocator #(
		.NUM_CHUNKS(NUM_CHUNKS),
		.CHUNK_BYTES(CHUNK_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// allocator state as the testbench sees it
	int unsigned fill_level [NUM_CHUNKS];
	bit pool_up;
	logic [CFG_W-1:0] chunk_count;

	alloc_result_t expected_results [$];
	int unsigned mismatches;
	bit quiet_mode;
	bit hold_rsp;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void clear_fills();
		for (int unsigned i = 0; i < NUM_CHUNKS; i++)
			fill_level[i] = 0;
	endfunction

	function automatic alloc_result_t predict_request(input logic [FUNC_W-1:0] fn,
			input logic [REQ_W-1:0] nbytes);
		alloc_result_t r;
		int unsigned active;
		int unsigned top;
		bit hit;
		r.status = STAT_INVALID;
		r.chunk_index = '0;
		r.byte_offset = '0;
		case (fn)
			FUNC_ALLOC: begin
				if (pool_up && nbytes >= 1 && nbytes <= CHUNK_BYTES) begin
					active = (chunk_count > NUM_CHUNKS) ? NUM_CHUNKS : chunk_count;
					r.status = STAT_NO_ROOM;
					hit = 1'b0;
					for (int unsigned i = 0; i < active; i++) begin
						if (!hit && fill_level[i] + nbytes <= CHUNK_BYTES) begin
							top = fill_level[i] + nbytes;
							r.status = STAT_DONE;
							r.chunk_index = IDX_W'(i);
							r.byte_offset = OFF_W'(fill_level[i]);
							// bump pointer stays 16-byte aligned
							fill_level[i] = (top + ALIGN_UNIT - 1) & ~(ALIGN_UNIT - 1);
							hit = 1'b1;
						end
					end
				end
			end
			FUNC_CREATE: begin
				if (pool_up) begin
					r.status = STAT_NOP;
				end else begin
					clear_fills();
					pool_up = 1'b1;
					r.status = STAT_DONE;
				end
			end
			FUNC_RELEASE: begin
				if (pool_up) begin
					clear_fills();
					pool_up = 1'b0;
					r.status = STAT_DONE;
				end else begin
					r.status = STAT_NOP;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [REQ_W-1:0] pick_bytes();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return REQ_W'($urandom_range(1, 64));
		if (r < 65)
			return REQ_W'($urandom_range(65, 1024));
		if (r < 80)
			return REQ_W'($urandom_range(1025, CHUNK_BYTES));
		if (r < 85)
			return REQ_W'(CHUNK_BYTES);
		if (r < 90)
			return '0;
		if (r < 95)
			return REQ_W'($urandom_range(CHUNK_BYTES + 1, (1 << REQ_W) - 1));
		return REQ_W'($urandom);
	endfunction

	// one transaction on the request channel; valid stays up for a back-to-back follower
	task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [REQ_W-1:0] nbytes);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.req_bytes <= nbytes;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		expected_results.push_back(predict_request(fn, nbytes));
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_chunk_count(input logic [CFG_W-1:0] value);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		chunk_count = value;
	endtask

	task automatic test_pool_absent();
		send_request(FUNC_ALLOC, 13'd16);
		send_request(FUNC_RELEASE, 13'd0);
		send_request(FUNC_RSVD, 13'd0);
	endtask

	task automatic test_alloc_basic();
		send_request(FUNC_CREATE, 13'd0);
		send_request(FUNC_CREATE, 13'd0);
		send_request(FUNC_ALLOC, 13'd1);
		send_request(FUNC_ALLOC, 13'd16);
		send_request(FUNC_ALLOC, 13'd4096);
		send_request(FUNC_ALLOC, 13'd0);
		send_request(FUNC_ALLOC, 13'd4097);
		send_request(FUNC_ALLOC, 13'd8191);
		send_request(FUNC_ALLOC, 13'd4064);
		send_request(FUNC_ALLOC, 13'd17);
		send_request(FUNC_RSVD, 13'd8191);
		send_request(FUNC_RELEASE, 13'd0);
		send_request(FUNC_ALLOC, 13'd1);
		send_request(FUNC_CREATE, 13'd0);
		send_request(FUNC_ALLOC, 13'd4080);
	endtask

	task automatic test_chunk_count();
		set_chunk_count(5'd1);
		send_request(FUNC_ALLOC, 13'd16);
		send_request(FUNC_ALLOC, 13'd1);
		set_chunk_count(5'd0);
		send_request(FUNC_ALLOC, 13'd1);
		set_chunk_count(5'd31);
		send_request(FUNC_ALLOC, 13'd4096);
		set_chunk_count(5'd16);
		send_request(FUNC_ALLOC, 13'd2000);
	endtask

	task automatic random_traffic(input int unsigned count);
		int unsigned r;
		logic [FUNC_W-1:0] fn;
		repeat (count) begin
			r = $urandom_range(0, 99);
			// mostly allocations into a live pool, the odd teardown and junk code
			if (!pool_up && r < 70)
				fn = FUNC_CREATE;
			else if (r < 2)
				fn = FUNC_RELEASE;
			else if (r < 4)
				fn = FUNC_CREATE;
			else if (r < 5)
				fn = FUNC_RSVD;
			else
				fn = FUNC_ALLOC;
			send_request(fn, pick_bytes());
		end
	endtask

	task automatic test_random();
		logic [CFG_W-1:0] counts [8];
		counts = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd0, 5'd9, 5'd17, 5'd16};
		foreach (counts[i]) begin
			set_chunk_count(counts[i]);
			quiet_mode = (i == 5);
			random_traffic(100);
		end
		quiet_mode = 1'b0;
	endtask

	task automatic test_backpressure();
		wait_for_results();
		hold_rsp = 1'b1;
		quiet_mode = 1'b1;
		repeat (12)
			send_request(FUNC_ALLOC, pick_bytes());
		quiet_mode = 1'b0;
	endtask

	task automatic test_sender_pause();
		random_traffic(6);
		wait_for_results();
		random_traffic(6);
	endtask

	// response side: random stalls, plus one long hold-off on request
	initial begin : rsp_drive
		int unsigned run_left;
		int unsigned held;
		run_left = 0;
		held = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (held != 0) begin
				held--;
			end else if (hold_rsp) begin
				hold_rsp = 1'b0;
				held = RSP_HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else if (quiet_mode) begin
				rsp_ch.ready <= 1'b1;
			end else if (run_left != 0) begin
				run_left--;
			end else if (rsp_ch.ready === 1'b1) begin
				run_left = pick_gap();
				if (run_left != 0) begin
					rsp_ch.ready <= 1'b0;
					run_left--;
				end else begin
					run_left = $urandom_range(0, 20);
				end
			end else begin
				rsp_ch.ready <= 1'b1;
				run_left = $urandom_range(0, 20);
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		alloc_result_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result status %0d chunk %0d offset %0d", $time,
					rsp_ch.status, rsp_ch.chunk_index, rsp_ch.byte_offset);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.chunk_index !== want.chunk_index) begin
					$display("%0t: chunk_index expected %0d got %0d", $time,
						want.chunk_index, rsp_ch.chunk_index);
					mismatches++;
				end
				if (rsp_ch.byte_offset !== want.byte_offset) begin
					$display("%0t: byte_offset expected %0d got %0d", $time,
						want.byte_offset, rsp_ch.byte_offset);
					mismatches++;
				end
			end
		end
	end

	// ends the run if no transaction moves on either channel for too long
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** chunked_bump_allocator: FAILED **");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_ALLOC;
		req_ch.req_bytes <= '0;
		mismatches = 0;
		quiet_mode = 1'b0;
		hold_rsp = 1'b0;
		clear_fills();
		pool_up = 1'b0;
		chunk_count = CFG_W'(CFG_RESET);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pool_absent();
		test_alloc_basic();
		test_chunk_count();
		test_backpressure();
		test_sender_pause();
		test_random();
		wait_for_results();

		if (mismatches == 0)
			$display("** chunked_bump_allocator: PASSED **");
		else
			$display("** chunked_bump_allocator: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/cba_pkg.sv
rtl/cba_req_if.sv
rtl/cba_rsp_if.sv
rtl/cba_cell.sv
rtl/chunked_bump_allocator.sv
tb/chunked_bump_allocator_test.sv
